// ----- src/lmsa_pkg.sv -----
// shared constants and types of the lumped mass scatter accumulator
package lmsa_pkg;

	localparam int NODE_COUNT  = 4096;
	localparam int NODE_W      = $clog2(NODE_COUNT);
	localparam int MAX_NODES   = 8;
	localparam int SLOT_W      = $clog2(MAX_NODES);
	localparam int CNT_W       = $clog2(MAX_NODES + 1);
	localparam int SHAPE_W     = 18;
	localparam int WEIGHT_W    = 20;
	localparam int DETJ_W      = 32;
	localparam int RHO_W       = 32;
	localparam int SUM_W       = 24;
	localparam int P_W         = 37;
	localparam int ACC_W       = 48;
	localparam int MASS_W      = 48;
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

	localparam logic [MASS_W-1:0]       MASS_MAX = {MASS_W{1'b1}};
	localparam logic signed [ACC_W-1:0] ACC_MAX  = {1'b0, {(ACC_W-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] ACC_MIN  = {1'b1, {(ACC_W-1){1'b0}}};

	typedef struct packed {
		logic                      store;
		logic [SLOT_W-1:0]         slot;
		logic [NODE_W-1:0]         node;
		logic signed [SHAPE_W-1:0] shape;
		logic signed [P_W-1:0]     p;
		logic [RHO_W-1:0]          rho;
		logic                      end_point;
		logic                      end_elem;
		logic [CNT_W-1:0]          n;
	} cmd_t;

endpackage

// ----- src/lmsa_in_if.sv -----
// input item channel
interface lmsa_in_if import lmsa_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic [NODE_W-1:0]          global_node;
	logic signed [SHAPE_W-1:0]  shape_value;
	logic [WEIGHT_W-1:0]        gauss_weight;
	logic signed [DETJ_W-1:0]   jacobian_det;
	logic [RHO_W-1:0]           density;
	logic                       last_node_of_point;
	logic                       last_point_of_element;

	modport source (
		output valid, global_node, shape_value, gauss_weight, jacobian_det, density,
		       last_node_of_point, last_point_of_element,
		input  ready
	);
	modport sink (
		input  valid, global_node, shape_value, gauss_weight, jacobian_det, density,
		       last_node_of_point, last_point_of_element,
		output ready
	);
endinterface

// ----- src/lmsa_out_if.sv -----
// result item channel
interface lmsa_out_if import lmsa_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [NODE_W-1:0] node_index;
	logic [MASS_W-1:0] node_mass;
	logic              last_update;

	modport source (output valid, node_index, node_mass, last_update, input ready);
	modport sink (input valid, node_index, node_mass, last_update, output ready);
endinterface

// ----- src/lmsa_ram.sv -----
// generic single write port ram with registered read
module lmsa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;
endmodule

// ----- src/lmsa_front.sv -----
// front end: accepts items, tracks slots and forms commands
module lmsa_front import lmsa_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	lmsa_in_if.sink item_in,
	input  logic  busy,
	input  logic  full,
	output logic  push,
	output cmd_t  push_cmd
);
	logic [CNT_W-1:0]                 cnt_q;
	logic                             store;
	logic signed [WEIGHT_W+DETJ_W:0]  wd_prod;

	always_comb begin
		store    = cnt_q < CNT_W'(MAX_NODES);
		wd_prod  = $signed({1'b0, item_in.gauss_weight}) * item_in.jacobian_det;
		push_cmd.store     = store;
		push_cmd.slot      = cnt_q[SLOT_W-1:0];
		push_cmd.node      = item_in.global_node;
		push_cmd.shape     = item_in.shape_value;
		push_cmd.p         = wd_prod[P_W+15:16];
		push_cmd.rho       = item_in.density;
		push_cmd.end_point = item_in.last_node_of_point;
		push_cmd.end_elem  = item_in.last_point_of_element;
		push_cmd.n         = store ? CNT_W'(cnt_q + 1'b1) : cnt_q;
	end

	assign item_in.ready = !full && !busy;
	assign push          = item_in.valid && item_in.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (push) begin
			if (item_in.last_node_of_point) begin
				cnt_q <= '0;
			end else if (store) begin
				cnt_q <= CNT_W'(cnt_q + 1'b1);
			end
		end
	end
endmodule

// ----- src/lmsa_queue.sv -----
// short command queue between front and back
module lmsa_queue import lmsa_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	input  logic pop,
	output logic head_valid,
	output cmd_t head
);
	cmd_t                mem_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_q;
	logic [QUEUE_AW-1:0] rd_q;
	logic [QUEUE_CW-1:0] cnt_q;

	assign full       = cnt_q == QUEUE_CW'(QUEUE_DEPTH);
	assign head_valid = cnt_q != '0;
	assign head       = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= QUEUE_AW'(wr_q + 1'b1);
			end
			if (pop) begin
				rd_q <= QUEUE_AW'(rd_q + 1'b1);
			end
			if (push && !pop) begin
				cnt_q <= QUEUE_CW'(cnt_q + 1'b1);
			end else if (pop && !push) begin
				cnt_q <= QUEUE_CW'(cnt_q - 1'b1);
			end
		end
	end
endmodule

// ----- src/lmsa_back.sv -----
// back end: slot buffers, point accumulation pipeline and mass store update
module lmsa_back import lmsa_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  head_valid,
	input  cmd_t  head,
	output logic  pop,
	output logic  busy,
	lmsa_out_if.source result_out
);
	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_POINT = 3'd2;
	localparam logic [2:0] ST_DRAIN = 3'd3;
	localparam logic [2:0] ST_E_RD  = 3'd4;
	localparam logic [2:0] ST_E_MUL = 3'd5;
	localparam logic [2:0] ST_E_SUM = 3'd6;
	localparam logic [2:0] ST_E_OUT = 3'd7;

	localparam int QPROD_W = SHAPE_W + SUM_W;
	localparam int Q_W     = QPROD_W - 16;
	localparam int PH_W    = P_W - 18;
	localparam int PP_W    = Q_W + PH_W;
	localparam int FULL_W  = 64;
	localparam int C_W     = FULL_W - 8;
	localparam int SUMX_W  = C_W + 1;

	logic [2:0] state_q;

	logic signed [SHAPE_W-1:0] shape_buf_q [MAX_NODES];
	logic [NODE_W-1:0]         node_buf_q [MAX_NODES];
	logic signed [SUM_W-1:0]   sum_q;
	logic signed [ACC_W-1:0]   acc_q [MAX_NODES];

	logic signed [P_W-1:0] p_q;
	logic [RHO_W-1:0]      rho_q;
	logic [CNT_W-1:0]      n_q;
	logic                  elem_q;
	logic [CNT_W-1:0]      a_q;
	logic [NODE_W-1:0]     clr_q;

	logic                        v_s1, v_s2, v_s3;
	logic signed [QPROD_W-1:0]   qprod_s1;
	logic [SLOT_W-1:0]           slot_s1, slot_s2, slot_s3;
	logic signed [PP_W-1:0]      pp_hi_s2, pp_lo_s2;
	logic signed [C_W-1:0]       c_s3;

	logic signed [Q_W-1:0]       q_val;
	logic signed [FULL_W-1:0]    full_val;
	logic signed [SUMX_W-1:0]    acc_sum;
	logic signed [ACC_W-1:0]     acc_sat;

	logic [MASS_W-1:0]           m_q;
	logic                        neg_q;
	logic [MASS_W-1:0]           old_q;
	logic [MASS_W-1:0]           mh_q;
	logic [63:0]                 ml_q;
	logic [MASS_W-1:0]           v_q;
	logic [MASS_W+31:0]          mfull;
	logic [MASS_W-1:0]           res;
	logic [MASS_W:0]             add_sum;
	logic signed [ACC_W-1:0]     acc_cur;
	logic [SLOT_W-1:0]           a_idx;
	logic                        issue;
	logic                        load_out;
	logic                        last_slot;

	logic                        out_v_q;
	logic [NODE_W-1:0]           node_index_q;
	logic [MASS_W-1:0]           node_mass_q;
	logic                        last_q;

	logic                        ram_we;
	logic [NODE_W-1:0]           ram_waddr;
	logic [MASS_W-1:0]           ram_wdata;
	logic [MASS_W-1:0]           ram_rdata;

	lmsa_ram #(.WIDTH(MASS_W), .DEPTH(NODE_COUNT)) u_mass (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (node_buf_q[a_idx]),
		.rdata (ram_rdata)
	);

	always_comb begin
		a_idx     = a_q[SLOT_W-1:0];
		acc_cur   = acc_q[a_idx];
		busy      = state_q == ST_CLEAR;
		pop       = (state_q == ST_IDLE) && head_valid;
		issue     = (state_q == ST_POINT) && (a_q < n_q);
		last_slot = CNT_W'(a_q + 1'b1) == n_q;
		load_out  = (state_q == ST_E_OUT) && (!out_v_q || result_out.ready);

		q_val    = qprod_s1[QPROD_W-1:16];
		full_val = (FULL_W'(pp_hi_s2) <<< 18) + FULL_W'(pp_lo_s2);
		acc_sum  = SUMX_W'(acc_q[slot_s3]) + SUMX_W'(c_s3);
		if (acc_sum > SUMX_W'(ACC_MAX)) begin
			acc_sat = ACC_MAX;
		end else if (acc_sum < SUMX_W'(ACC_MIN)) begin
			acc_sat = ACC_MIN;
		end else begin
			acc_sat = acc_sum[ACC_W-1:0];
		end

		mfull   = {mh_q, 32'b0} + {{(MASS_W-32){1'b0}}, ml_q};
		add_sum = {1'b0, old_q} + {1'b0, v_q};
		if (neg_q) begin
			res = (old_q > v_q) ? old_q - v_q : '0;
		end else begin
			res = add_sum[MASS_W] ? MASS_MAX : add_sum[MASS_W-1:0];
		end

		ram_we    = 1'b0;
		ram_waddr = node_buf_q[a_idx];
		ram_wdata = res;
		if (state_q == ST_CLEAR) begin
			ram_we    = 1'b1;
			ram_waddr = clr_q;
			ram_wdata = '0;
		end else if (load_out) begin
			ram_we = 1'b1;
		end
	end

	// slot buffers and datapath payload
	always_ff @(posedge clk) begin
		if (pop && head.store) begin
			shape_buf_q[head.slot] <= head.shape;
			node_buf_q[head.slot]  <= head.node;
		end
		if (pop && head.end_point) begin
			p_q   <= head.p;
			rho_q <= head.rho;
			n_q   <= head.n;
		end
		qprod_s1 <= shape_buf_q[a_idx] * sum_q;
		slot_s1  <= a_idx;
		pp_hi_s2 <= q_val * $signed(p_q[P_W-1:18]);
		pp_lo_s2 <= q_val * $signed({1'b0, p_q[17:0]});
		slot_s2  <= slot_s1;
		c_s3     <= full_val[FULL_W-1:8];
		slot_s3  <= slot_s2;
		if (state_q == ST_E_RD) begin
			neg_q <= acc_cur[ACC_W-1];
			m_q   <= acc_cur[ACC_W-1] ? MASS_W'(-acc_cur) : MASS_W'(acc_cur);
		end
		if (state_q == ST_E_MUL) begin
			old_q <= ram_rdata;
			mh_q  <= m_q[MASS_W-1:32] * rho_q;
			ml_q  <= m_q[31:0] * rho_q;
		end
		if (state_q == ST_E_SUM) begin
			v_q <= (|mfull[MASS_W+31:MASS_W+16]) ? MASS_MAX : mfull[MASS_W+15:16];
		end
		if (load_out) begin
			node_index_q <= node_buf_q[a_idx];
			node_mass_q  <= res;
			last_q       <= last_slot;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			sum_q   <= '0;
			elem_q  <= 1'b0;
			a_q     <= '0;
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			out_v_q <= 1'b0;
			for (int i = 0; i < MAX_NODES; i++) begin
				acc_q[i] <= '0;
			end
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			if (v_s3) begin
				acc_q[slot_s3] <= acc_sat;
			end
			if (load_out) begin
				out_v_q <= 1'b1;
			end else if (result_out.ready) begin
				out_v_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= NODE_W'(clr_q + 1'b1);
					if (clr_q == NODE_W'(NODE_COUNT - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (pop) begin
						if (head.store) begin
							sum_q <= sum_q + SUM_W'(head.shape);
						end
						if (head.end_point) begin
							elem_q  <= head.end_elem;
							a_q     <= '0;
							state_q <= ST_POINT;
						end
					end
				end
				ST_POINT: begin
					if (issue) begin
						a_q <= CNT_W'(a_q + 1'b1);
					end else begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (!v_s1 && !v_s2 && !v_s3) begin
						sum_q <= '0;
						a_q   <= '0;
						state_q <= elem_q ? ST_E_RD : ST_IDLE;
					end
				end
				ST_E_RD:  state_q <= ST_E_MUL;
				ST_E_MUL: state_q <= ST_E_SUM;
				ST_E_SUM: state_q <= ST_E_OUT;
				ST_E_OUT: begin
					if (load_out) begin
						a_q <= CNT_W'(a_q + 1'b1);
						if (last_slot) begin
							for (int i = 0; i < MAX_NODES; i++) begin
								acc_q[i] <= '0;
							end
							state_q <= ST_IDLE;
						end else begin
							state_q <= ST_E_RD;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign result_out.valid       = out_v_q;
	assign result_out.node_index  = node_index_q;
	assign result_out.node_mass   = node_mass_q;
	assign result_out.last_update = last_q;
endmodule

// ----- src/lumped_mass_scatter_accumulate.sv -----
// lumped mass scatter accumulator top level
// an ordinary item is written into the queue on acceptance and into its slot when the back end pops it
// a point end item holds the back end until each of its n slots has passed the s1, s2, s3 pipeline
// an element end then reads, multiplies, sums and outputs each slot in turn, one result per slot
// the four entry command queue lets the front accept items while the back end works
// after reset all 4096 mass store entries are cleared with item_in.ready held low
module lumped_mass_scatter_accumulate import lmsa_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	lmsa_in_if.sink    item_in,
	lmsa_out_if.source result_out
);
	logic busy;
	logic full;
	logic push;
	cmd_t push_cmd;
	logic pop;
	logic head_valid;
	cmd_t head;

	lmsa_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.item_in  (item_in),
		.busy     (busy),
		.full     (full),
		.push     (push),
		.push_cmd (push_cmd)
	);

	lmsa_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.full       (full),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	lmsa_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.busy       (busy),
		.result_out (result_out)
	);
endmodule
